[rtl/hlx_pkg.sv]
// Shared types and constants for the header/length/XOR frame receiver.
// Used by the register block, the frame parser and the top level.
package hlx_pkg;

  typedef enum logic [1:0] {
    KIND_BODY = 2'd0,
    KIND_GOOD = 2'd1,
    KIND_BAD  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    REG_FIRST_HEADER  = 2'd0,
    REG_SECOND_HEADER = 2'd1,
    REG_MIN_LENGTH    = 2'd2,
    REG_MAX_LENGTH    = 2'd3
  } reg_index_t;

  localparam logic [7:0] FIRST_HEADER_RESET  = 8'hAA;
  localparam logic [7:0] SECOND_HEADER_RESET = 8'h55;
  localparam logic [7:0] MIN_LENGTH_RESET    = 8'd3;
  localparam logic [7:0] MAX_LENGTH_RESET    = 8'd150;

  // Shortest frame: two headers and the length byte, which doubles as checksum.
  localparam logic [7:0] SHORTEST_FRAME = 8'd3;
  localparam logic [7:0] LENGTH_POS     = 8'd2;
  localparam logic [7:0] FIRST_BODY_POS = 8'd3;

  localparam int ADDR_W = 4;

  typedef struct packed {
    logic [7:0] first_header;
    logic [7:0] second_header;
    logic [7:0] min_length;
    logic [7:0] max_length;
  } cfg_t;

endpackage

[rtl/hlx_stream_if.sv]
// Valid/ready channel interfaces for received bytes and for parser results.
// No dependencies.
interface hlx_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface hlx_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] body_byte;
  logic [7:0] position;
  logic [7:0] total_length;

  modport source (output valid, output kind, output body_byte, output position,
                  output total_length, input ready);
  modport sink   (input valid, input kind, input body_byte, input position,
                  input total_length, output ready);
endinterface

[rtl/hlx_regs.sv]
// APB-style configuration registers of the frame receiver.
// Depends on hlx_pkg for the register indexes, reset values and cfg_t.
module hlx_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [hlx_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output hlx_pkg::cfg_t              cfg
);
  import hlx_pkg::*;

  reg_index_t idx;
  logic       wr_en;

  assign pready = 1'b1;
  assign idx    = reg_index_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.first_header  <= FIRST_HEADER_RESET;
      cfg.second_header <= SECOND_HEADER_RESET;
      cfg.min_length    <= MIN_LENGTH_RESET;
      cfg.max_length    <= MAX_LENGTH_RESET;
    end else if (wr_en) begin
      unique case (idx)
        REG_FIRST_HEADER:  cfg.first_header  <= pwdata[7:0];
        REG_SECOND_HEADER: cfg.second_header <= pwdata[7:0];
        REG_MIN_LENGTH:    cfg.min_length    <= pwdata[7:0];
        REG_MAX_LENGTH:    cfg.max_length    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = 32'd0;
    unique case (idx)
      REG_FIRST_HEADER:  prdata[7:0] = cfg.first_header;
      REG_SECOND_HEADER: prdata[7:0] = cfg.second_header;
      REG_MIN_LENGTH:    prdata[7:0] = cfg.min_length;
      REG_MAX_LENGTH:    prdata[7:0] = cfg.max_length;
      default:           prdata      = 32'd0;
    endcase
  end

endmodule

[rtl/hlx_parser.sv]
// Frame parser: hunt state, length check, running XOR and the result register.
// Depends on hlx_pkg and on the channel interfaces in hlx_stream_if.sv.
module hlx_parser (
  input  logic          clk,
  input  logic          rst,
  input  hlx_pkg::cfg_t cfg,
  hlx_byte_if.sink      bytes,
  hlx_result_if.source  results
);
  import hlx_pkg::*;

  typedef enum logic [3:0] {
    PH_HUNT1 = 4'b0001,
    PH_HUNT2 = 4'b0010,
    PH_LEN   = 4'b0100,
    PH_BODY  = 4'b1000
  } phase_t;

  phase_t     phase, phase_next;
  logic [7:0] length_seen, length_seen_next;
  logic [7:0] byte_count, byte_count_next;
  logic [7:0] running_xor, running_xor_next;

  logic       accept;
  logic       emit;
  kind_t      emit_kind;
  logic [7:0] emit_pos;
  logic [7:0] emit_len;
  logic [7:0] b;
  logic       len_bad;
  logic       last_byte;

  // A new word enters whenever the result register is empty or being drained.
  assign bytes.ready = !results.valid || results.ready;
  assign accept      = bytes.valid && bytes.ready;
  assign b           = bytes.rx_byte;

  assign len_bad   = (b < SHORTEST_FRAME) || (b < cfg.min_length) || (b > cfg.max_length);
  assign last_byte = ({1'b0, byte_count} + 9'd1) >= {1'b0, length_seen};

  always_comb begin
    phase_next       = phase;
    length_seen_next = length_seen;
    byte_count_next  = byte_count;
    running_xor_next = running_xor;
    emit             = 1'b0;
    emit_kind        = KIND_BODY;
    emit_pos         = byte_count;
    emit_len         = length_seen;
    unique case (phase)
      PH_HUNT1: begin
        if (b == cfg.first_header) begin
          running_xor_next = b;
          phase_next       = PH_HUNT2;
        end
      end
      PH_HUNT2: begin
        if (b != cfg.second_header) begin
          phase_next       = PH_HUNT1;
          length_seen_next = 8'd0;
          byte_count_next  = 8'd0;
          running_xor_next = 8'd0;
        end else begin
          running_xor_next = running_xor ^ b;
          phase_next       = PH_LEN;
        end
      end
      PH_LEN: begin
        if (len_bad || b == SHORTEST_FRAME) begin
          phase_next       = PH_HUNT1;
          length_seen_next = 8'd0;
          byte_count_next  = 8'd0;
          running_xor_next = 8'd0;
          // The shortest frame ends on its length byte, which is the checksum.
          if (!len_bad) begin
            emit      = 1'b1;
            emit_kind = (b == running_xor) ? KIND_GOOD : KIND_BAD;
            emit_pos  = LENGTH_POS;
            emit_len  = b;
          end
        end else begin
          length_seen_next = b;
          running_xor_next = running_xor ^ b;
          byte_count_next  = FIRST_BODY_POS;
          phase_next       = PH_BODY;
        end
      end
      PH_BODY: begin
        emit = 1'b1;
        if (last_byte) begin
          emit_kind        = (b == running_xor) ? KIND_GOOD : KIND_BAD;
          phase_next       = PH_HUNT1;
          length_seen_next = 8'd0;
          byte_count_next  = 8'd0;
          running_xor_next = 8'd0;
        end else begin
          running_xor_next = running_xor ^ b;
          byte_count_next  = byte_count + 8'd1;
        end
      end
      default: begin
        phase_next = PH_HUNT1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HUNT1;
      length_seen <= 8'd0;
      byte_count  <= 8'd0;
      running_xor <= 8'd0;
    end else if (accept) begin
      phase       <= phase_next;
      length_seen <= length_seen_next;
      byte_count  <= byte_count_next;
      running_xor <= running_xor_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (accept) begin
      results.valid <= emit;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      results.kind         <= emit_kind;
      results.body_byte    <= b;
      results.position     <= emit_pos;
      results.total_length <= emit_len;
    end
  end

endmodule

[rtl/header_length_xor_frame_receiver.sv]
// Header/length/XOR-checksum frame receiver, top level.
// Depends on hlx_pkg, hlx_stream_if.sv, hlx_regs and hlx_parser.
//
// Received bytes arrive one word at a time on the bytes channel. The block
// hunts for the two header bytes, checks the length byte against min_length
// and max_length, then passes each body byte out on the results channel with
// its frame position and the frame length. The last frame byte yields a
// frame-end word that says whether it matched the XOR of all earlier bytes.
// Headers, rejected bytes and a longer frame's length byte yield no word.
//
// One byte is accepted every cycle while results drain. A result word is
// loaded into the output register in the cycle after its byte is accepted.
// The output register is drained in the same cycle that a new byte is
// accepted, so throughput stays at one word per cycle while the receiver
// takes results; a stall drops bytes.ready until the pending result is taken.
//
// Synchronous reset returns the parser to the hunt for the first header,
// empties the output register and loads the register reset values
// (0xAA, 0x55, 3, 150). Registers sit at byte addresses 0, 4, 8 and 12.
module header_length_xor_frame_receiver (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [hlx_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  hlx_byte_if.sink                   bytes,
  hlx_result_if.source               results
);
  import hlx_pkg::*;

  cfg_t cfg;

  hlx_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  hlx_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .bytes   (bytes),
    .results (results)
  );

endmodule

[verif/hlx_frame_tracker_pkg.sv]
`timescale 1ns / 100ps
// Frame tracker for the header/length/XOR receiver bench: mirrors the parser
// state and queues the result words it expects. Depends on hlx_pkg.
package hlx_frame_tracker_pkg;
  import hlx_pkg::*;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] body_byte;
    logic [7:0] position;
    logic [7:0] total_length;
  } frame_word_t;

  typedef enum logic [1:0] {
    SEEK_FIRST,
    SEEK_SECOND,
    TAKE_LENGTH,
    TAKE_BODY
  } rx_phase_t;

  localparam int REPORT_LIMIT = 10;

  class hlx_frame_tracker;
    cfg_t        cfg;
    rx_phase_t   rx_phase;
    logic [7:0]  frame_len;
    logic [7:0]  next_pos;
    logic [7:0]  xor_sum;
    frame_word_t expected_words[$];
    int          errors;

    function new();
      cfg = '{first_header: FIRST_HEADER_RESET, second_header: SECOND_HEADER_RESET,
              min_length: MIN_LENGTH_RESET, max_length: MAX_LENGTH_RESET};
      errors = 0;
      restart();
    endfunction

    function void restart();
      rx_phase  = SEEK_FIRST;
      frame_len = '0;
      next_pos  = '0;
      xor_sum   = '0;
    endfunction

    function void write_reg(reg_index_t idx, logic [7:0] v);
      case (idx)
        REG_FIRST_HEADER:  cfg.first_header  = v;
        REG_SECOND_HEADER: cfg.second_header = v;
        REG_MIN_LENGTH:    cfg.min_length    = v;
        REG_MAX_LENGTH:    cfg.max_length    = v;
        default: ;
      endcase
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= REPORT_LIMIT) $display("ERROR at %0t: %s", $realtime, msg);
    endfunction

    function void note_byte(logic [7:0] b);
      frame_word_t w;
      case (rx_phase)
        SEEK_FIRST: begin
          if (b == cfg.first_header) begin
            xor_sum  = b;
            rx_phase = SEEK_SECOND;
          end
        end
        SEEK_SECOND: begin
          // A wrong second header is swallowed, not retried as a first header.
          if (b != cfg.second_header) begin
            restart();
          end else begin
            xor_sum  = xor_sum ^ b;
            rx_phase = TAKE_LENGTH;
          end
        end
        TAKE_LENGTH: begin
          if (b < SHORTEST_FRAME || b < cfg.min_length || b > cfg.max_length) begin
            restart();
          end else if (b == SHORTEST_FRAME) begin
            // The length byte doubles as the checksum of a three-byte frame.
            w.kind         = (b == xor_sum) ? KIND_GOOD : KIND_BAD;
            w.body_byte    = b;
            w.position     = LENGTH_POS;
            w.total_length = b;
            expected_words.push_back(w);
            restart();
          end else begin
            frame_len = b;
            xor_sum   = xor_sum ^ b;
            next_pos  = FIRST_BODY_POS;
            rx_phase  = TAKE_BODY;
          end
        end
        default: begin
          w.body_byte    = b;
          w.position     = next_pos;
          w.total_length = frame_len;
          if ({1'b0, next_pos} + 9'd1 >= {1'b0, frame_len}) begin
            w.kind = (b == xor_sum) ? KIND_GOOD : KIND_BAD;
            expected_words.push_back(w);
            restart();
          end else begin
            w.kind = KIND_BODY;
            expected_words.push_back(w);
            xor_sum  = xor_sum ^ b;
            next_pos = next_pos + 8'd1;
          end
        end
      endcase
    endfunction

    function void check_word(frame_word_t got);
      frame_word_t exp;
      if (expected_words.size() == 0) begin
        flag($sformatf("unexpected word kind=%0d byte=%02h pos=%0d len=%0d",
                       got.kind, got.body_byte, got.position, got.total_length));
        return;
      end
      exp = expected_words.pop_front();
      if (got.kind !== exp.kind || got.body_byte !== exp.body_byte ||
          got.position !== exp.position || got.total_length !== exp.total_length)
        flag($sformatf({"word mismatch: expected kind=%0d byte=%02h pos=%0d len=%0d,",
                        " got kind=%0d byte=%02h pos=%0d len=%0d"},
                       exp.kind, exp.body_byte, exp.position, exp.total_length,
                       got.kind, got.body_byte, got.position, got.total_length));
    endfunction
  endclass

endpackage

[verif/tb_header_length_xor_frame_receiver.sv]
`timescale 1ns / 100ps
// Bench for header_length_xor_frame_receiver: random and directed byte
// streams, register writes between phases, results checked against a tracker.
// Depends on hlx_pkg, hlx_stream_if.sv and hlx_frame_tracker_pkg.
module tb_header_length_xor_frame_receiver;
  import hlx_pkg::*;
  import hlx_frame_tracker_pkg::*;

  localparam int STALL_LIMIT = 2000;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  hlx_byte_if   bytes_if ();
  hlx_result_if results_if ();

  header_length_xor_frame_receiver dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .bytes   (bytes_if),
    .results (results_if)
  );

  hlx_frame_tracker tracker = new();

  bit gaps_on;
  bit stalls_on;
  int phase_bytes;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: the receiver stalls in bursts, mostly short, now and then long.
  initial begin : result_ready_driver
    int stall_left;
    stall_left = 0;
    results_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left == 0 && stalls_on && $urandom_range(0, 99) < 25)
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                 : $urandom_range(1, 3);
      if (stall_left > 0) begin
        results_if.ready <= 1'b0;
        stall_left--;
      end else begin
        results_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    frame_word_t got;
    if (!rst) begin
      if (results_if.valid && results_if.ready) begin
        got.kind         = kind_t'(results_if.kind);
        got.body_byte    = results_if.body_byte;
        got.position     = results_if.position;
        got.total_length = results_if.total_length;
        tracker.check_word(got);
      end
      if (bytes_if.valid && bytes_if.ready) tracker.note_byte(bytes_if.rx_byte);
    end
  end

  always @(posedge clk) begin
    if (rst || (bytes_if.valid && bytes_if.ready) ||
        (results_if.valid && results_if.ready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // valid stays high from one word to the next unless a gap is drawn.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      bytes_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    bytes_if.valid   <= 1'b1;
    bytes_if.rx_byte <= b;
    @(posedge clk);
    while (!bytes_if.ready) @(posedge clk);
    phase_bytes++;
  endtask

  task automatic send_frame(input logic [7:0] len, input bit bad_sum);
    logic [7:0] sum;
    logic [7:0] b;
    int i;
    sum = tracker.cfg.first_header ^ tracker.cfg.second_header ^ len;
    send_byte(tracker.cfg.first_header);
    send_byte(tracker.cfg.second_header);
    send_byte(len);
    if (len > SHORTEST_FRAME) begin
      for (i = 4; i < int'(len); i++) begin
        b = 8'($urandom);
        send_byte(b);
        sum = sum ^ b;
      end
      send_byte(bad_sum ? sum ^ 8'($urandom_range(1, 255)) : sum);
    end
  endtask

  // Holds off the sender until every expected word is out and the output
  // register has had time to drain.
  task automatic settle();
    @(negedge clk);
    bytes_if.valid <= 1'b0;
    while (tracker.expected_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [7:0] v);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'd0, v};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    tracker.write_reg(idx, v);
    // Read the register straight back.
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== {24'd0, v})
      tracker.flag($sformatf("register %0d read back %08h, expected %02h", idx, prdata, v));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Mostly well-formed frames with random bodies; the rest is line noise,
  // wrong second headers and lengths outside the window.
  task automatic random_traffic(input int budget);
    int lo;
    int hi;
    int len;
    phase_bytes = 0;
    while (phase_bytes < budget) begin
      lo = (tracker.cfg.min_length < SHORTEST_FRAME) ? int'(SHORTEST_FRAME)
                                                     : int'(tracker.cfg.min_length);
      hi = int'(tracker.cfg.max_length);
      case ($urandom_range(0, 9))
        0: repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
        1: begin
          send_byte(tracker.cfg.first_header);
          send_byte(8'($urandom));
        end
        2: begin
          send_byte(tracker.cfg.first_header);
          send_byte(tracker.cfg.second_header);
          if (hi < 255 && $urandom_range(0, 1) == 1)
            send_byte(8'($urandom_range(hi + 1, 255)));
          else if (lo > 3 && $urandom_range(0, 1) == 1)
            send_byte(8'($urandom_range(0, lo - 1)));
          else
            send_byte(8'($urandom_range(0, 2)));
        end
        default: begin
          if (lo > hi)
            len = $urandom_range(3, 20);
          else if ($urandom_range(0, 9) == 0)
            len = $urandom_range(lo, hi);
          else
            len = $urandom_range(lo, (hi < lo + 9) ? hi : lo + 9);
          send_frame(8'(len), $urandom_range(0, 4) == 0);
        end
      endcase
    end
  endtask

  initial begin : stimulus
    logic [7:0] opening[] = '{8'h00, 8'hFF,
                              8'hAA, 8'h55, 8'h03,
                              8'hAA, 8'h55, 8'h04, 8'h00, 8'hFB,
                              8'hAA, 8'hAA, 8'h55,
                              8'hAA, 8'h55, 8'h05, 8'hFF, 8'h00,
                              8'hAA, 8'h55, 8'h02,
                              8'hAA, 8'h55, 8'd151,
                              8'hAA, 8'h55, 8'h00};
    rst              = 1'b1;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    bytes_if.valid   = 1'b0;
    bytes_if.rx_byte = '0;
    gaps_on          = 1'b1;
    stalls_on        = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset values: short frames, a swallowed second header, bad lengths.
    foreach (opening[i]) send_byte(opening[i]);

    // A register write in the middle of a frame leaves its length alone.
    send_byte(8'hAA);
    send_byte(8'h55);
    send_byte(8'h07);
    send_byte(8'h11);
    send_byte(8'h22);
    settle();
    write_reg(REG_MAX_LENGTH, 8'd4);
    send_byte(8'h33);
    send_byte(8'hFF ^ 8'h07 ^ 8'h11 ^ 8'h22 ^ 8'h33);
    send_frame(8'd4, 1'b0);
    send_frame(8'd5, 1'b0);

    // Headers whose XOR is three, and a minimum below the shortest frame.
    settle();
    write_reg(REG_FIRST_HEADER, 8'h00);
    write_reg(REG_SECOND_HEADER, 8'h03);
    write_reg(REG_MIN_LENGTH, 8'd0);
    write_reg(REG_MAX_LENGTH, 8'd3);
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    send_frame(8'd3, 1'b0);
    send_frame(8'd2, 1'b0);
    send_frame(8'd4, 1'b0);
    random_traffic(60);

    // Only the longest frame is allowed.
    settle();
    write_reg(REG_FIRST_HEADER, 8'hFF);
    write_reg(REG_SECOND_HEADER, 8'hFF);
    write_reg(REG_MIN_LENGTH, 8'd255);
    write_reg(REG_MAX_LENGTH, 8'd255);
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    random_traffic(200);

    // Minimum above maximum: nothing gets through.
    settle();
    write_reg(REG_FIRST_HEADER, 8'h5A);
    write_reg(REG_MIN_LENGTH, 8'd200);
    write_reg(REG_MAX_LENGTH, 8'd10);
    random_traffic(60);

    settle();
    write_reg(REG_FIRST_HEADER, 8'($urandom));
    write_reg(REG_SECOND_HEADER, 8'($urandom));
    write_reg(REG_MIN_LENGTH, SHORTEST_FRAME);
    write_reg(REG_MAX_LENGTH, 8'd255);
    stalls_on = 1'b0;
    random_traffic(150);

    settle();
    write_reg(REG_FIRST_HEADER, FIRST_HEADER_RESET);
    write_reg(REG_SECOND_HEADER, SECOND_HEADER_RESET);
    write_reg(REG_MIN_LENGTH, MIN_LENGTH_RESET);
    write_reg(REG_MAX_LENGTH, MAX_LENGTH_RESET);
    gaps_on   = 1'b0;
    stalls_on = 1'b1;
    random_traffic(150);

    @(negedge clk);
    bytes_if.valid <= 1'b0;
    while (tracker.expected_words.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (tracker.errors == 0 && tracker.expected_words.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
